// ===== hw/rtl/meva_pkg.sv =====
// ---------------------------------------------------------------------------
// Mean entropy / variance accumulator package
// Shared types and fixed constants for the controller, datapath and divider.
// ---------------------------------------------------------------------------
package meva_pkg;

   localparam int LOG_FRAC    = 24;
   localparam int LOG_CNT_W   = 5;
   localparam int TOTAL_W     = 48;
   localparam int OUT_W       = 24;
   localparam int CNT_W       = 16;
   localparam int MODE_W      = 2;
   localparam int GCOUNT_W    = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic [MODE_W-1:0] MODE_ENTROPY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VARIANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOTH     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GENOTYPES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INDIVIDUALS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POSITIONS  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOG, ST_LN, ST_PLN, ST_ACC, ST_VSQ, ST_VACC, ST_DIVE, ST_DIVV, ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic log_step;
      logic ln_mul;
      logic pln_mul;
      logic acc;
      logic vsq;
      logic vacc;
      logic div_start;
      logic div_sel;
      logic ent_latch;
      logic res_load;
   } cmd_type;

   typedef struct packed {
      logic geno_end;
      logic ind_end;
      logic div_busy;
      logic rsp_full;
   } status_type;

endpackage

// ===== hw/rtl/meva_div.sv =====
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module meva_div import meva_pkg::*; #(
   parameter int DW = 48,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [VW:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// ===== hw/rtl/meva_ctrl.sv =====
// ---------------------------------------------------------------------------
// Accumulator controller
// Sequences the log, multiply, accumulate and divide steps of each transaction.
// ---------------------------------------------------------------------------
module meva_ctrl import meva_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic [LOG_CNT_W-1:0] iter_ff, iter_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOG;
         ST_LOG:  if (iter_ff == LOG_CNT_W'(LOG_FRAC - 1)) state_in = ST_LN;
         ST_LN:   state_in = ST_PLN;
         ST_PLN:  state_in = ST_ACC;
         ST_ACC:  state_in = status.geno_end ? ST_VSQ : ST_IDLE;
         ST_VSQ:  state_in = ST_VACC;
         ST_VACC: state_in = status.ind_end ? ST_DIVE : ST_IDLE;
         ST_DIVE: if (!status.div_busy) state_in = ST_DIVV;
         ST_DIVV: if (!status.div_busy) state_in = ST_FIN;
         ST_FIN:  if (!status.rsp_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      iter_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LOG: begin
            cmd.log_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
         end
         ST_LN:  cmd.ln_mul  = 1'b1;
         ST_PLN: cmd.pln_mul = 1'b1;
         ST_ACC: cmd.acc     = 1'b1;
         ST_VSQ: cmd.vsq     = 1'b1;
         ST_VACC: begin
            cmd.vacc      = 1'b1;
            cmd.div_start = status.ind_end;
         end
         ST_DIVE: begin
            cmd.ent_latch = !status.div_busy;
            cmd.div_start = !status.div_busy;
            cmd.div_sel   = 1'b1;
         end
         ST_DIVV: ;
         ST_FIN: cmd.res_load = !status.rsp_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOG |-> iter_ff < LOG_CNT_W'(LOG_FRAC))
      else $error("log iteration count overran");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && !status.rsp_full |=> status.rsp_full)
      else $error("result was not registered");
endmodule

// ===== hw/rtl/meva_dp.sv =====
// ---------------------------------------------------------------------------
// Accumulator datapath
// Configuration registers, log unit, accumulators, counters and result register.
// ---------------------------------------------------------------------------
module meva_dp import meva_pkg::*; #(
   parameter int MAX_GENOTYPES  = 16,
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [PROB_FRAC_BITS:0] req_prob,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    div_busy,
   output logic [TOTAL_W-1:0]      div_dividend,
   output logic [CNT_W-1:0]        div_divisor,
   input  logic [TOTAL_W-1:0]      div_quotient,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_entropy_mean,
   output logic [OUT_W-1:0]        rsp_variance_mean,
   output logic                    rsp_last_position
);
   localparam int F    = PROB_FRAC_BITS;
   localparam int PW   = F + 1;
   localparam int MSBW = $clog2(PW);
   localparam int KW   = $clog2(MAX_GENOTYPES);
   localparam int SW   = F + 2 * KW;
   localparam int SSW  = F + 3 * KW;
   localparam int SQW  = 2 * SW - F;
   localparam int DW   = (SSW > SQW ? SSW : SQW) + 1;
   localparam int MAGW = $clog2(F + 1) + LOG_FRAC;
   localparam int SHR  = F >= 16 ? F - 16 : 0;
   localparam int SHL  = F >= 16 ? 0 : 16 - F;

   logic [MODE_W-1:0]   mode_ff;
   logic [GCOUNT_W-1:0] gcount_ff;
   logic [CNT_W-1:0]    icount_ff, pcount_ff;

   logic [PW-1:0]       p_ff;
   logic [MSBW-1:0]     msb_ff;
   logic [30:0]         y_ff;
   logic [LOG_FRAC-1:0] frac_ff;
   logic [MAGW-1:0]     nln_ff;
   logic [TOTAL_W-1:0]  term_ff;
   logic [TOTAL_W-1:0]  ent_tot_ff;
   logic signed [TOTAL_W-1:0] var_tot_ff;
   logic [SW-1:0]       s_ff;
   logic [SSW-1:0]      ss_ff;
   logic [SQW-1:0]      sq_ff;
   logic [KW-1:0]       geno_ff;
   logic [CNT_W-1:0]    ind_ff, pos_ff;
   logic [OUT_W-1:0]    ent_mean_ff;
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_ent_ff, rsp_var_ff;
   logic                rsp_last_ff;

   logic [PW-1:0]       p_clamp;
   logic [MSBW-1:0]     msb_c;
   logic [61:0]         ysq;
   logic [31:0]         ysh;
   logic [MAGW-1:0]     mag;
   logic [MAGW+31:0]    ln_prod;
   logic [PW+MAGW-1:0]  pln_prod;
   logic [KW:0]         gc_eff;
   logic [CNT_W-1:0]    ic_eff, pc_eff;
   logic [2*KW-1:0]     kk;
   logic [2*SW-1:0]     s_sq;
   logic [DW-1:0]       diff_mag;
   logic                diff_neg;
   logic [63:0]         m_sh;
   logic signed [32:0]  v_ind;
   logic [TOTAL_W-1:0]  ent_q;
   logic [OUT_W-1:0]    var_q;
   logic                last_c;

   always_comb begin
      p_clamp = (req_prob > PW'(1 << F)) ? PW'(1 << F) : req_prob;
      msb_c   = '0;
      for (int i = 1; i < PW; i++) begin
         if (p_clamp[i]) msb_c = MSBW'(i);
      end
   end

   assign ysq      = 62'(y_ff) * 62'(y_ff);
   assign ysh      = ysq[61:30];
   assign mag      = (MAGW'(F - int'(msb_ff)) << LOG_FRAC) - MAGW'(frac_ff);
   assign ln_prod  = (MAGW+32)'(mag) * (MAGW+32)'(LN2_Q32);
   assign pln_prod = (PW+MAGW)'(p_ff) * (PW+MAGW)'(nln_ff);
   assign kk       = (2*KW)'(geno_ff) * (2*KW)'(geno_ff);
   assign s_sq     = (2*SW)'(s_ff) * (2*SW)'(s_ff);

   always_comb begin
      if (gcount_ff == '0) gc_eff = (KW+1)'(1);
      else if (32'(gcount_ff) > 32'(MAX_GENOTYPES)) gc_eff = (KW+1)'(MAX_GENOTYPES);
      else gc_eff = (KW+1)'(gcount_ff);
      ic_eff = (icount_ff == '0) ? CNT_W'(1) : icount_ff;
      pc_eff = (pcount_ff == '0) ? CNT_W'(1) : pcount_ff;
   end

   assign status.geno_end = (32'(geno_ff) + 1) >= 32'(gc_eff);
   assign status.ind_end  = (32'(ind_ff) + 1) >= 32'(ic_eff);
   assign status.div_busy = div_busy;
   assign status.rsp_full = rsp_valid_ff;
   assign last_c          = (32'(pos_ff) + 1) >= 32'(pc_eff);

   always_comb begin
      diff_neg = DW'(sq_ff) > DW'(ss_ff);
      diff_mag = diff_neg ? DW'(sq_ff) - DW'(ss_ff) : DW'(ss_ff) - DW'(sq_ff);
      m_sh     = (F >= 16) ? (64'(diff_mag) >> SHR) : (64'(diff_mag) << SHL);
      if (diff_neg) begin
         v_ind = (m_sh > 64'd2147483648) ? -33'sd2147483648 : -$signed(33'(m_sh));
      end else begin
         v_ind = (m_sh > 64'd2147483647) ? 33'sd2147483647 : $signed(33'(m_sh));
      end
   end

   assign div_dividend = cmd.div_sel ? (var_tot_ff > 0 ? TOTAL_W'(var_tot_ff) : '0)
                                     : ent_tot_ff;
   assign div_divisor  = ic_eff;
   assign ent_q = (div_quotient > TOTAL_W'(8388608)) ? TOTAL_W'(8388608) : div_quotient;
   assign var_q = (div_quotient > TOTAL_W'(24'hFFFFFF)) ? 24'hFFFFFF : div_quotient[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff    <= p_clamp;
         msb_ff  <= msb_c;
         y_ff    <= 31'(p_clamp) << (30 - int'(msb_c));
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         y_ff    <= ysh[31] ? ysh[31:1] : ysh[30:0];
         frac_ff <= {frac_ff[LOG_FRAC-2:0], ysh[31]};
      end
      if (cmd.ln_mul)  nln_ff  <= ln_prod[MAGW+31:32];
      if (cmd.pln_mul) term_ff <= TOTAL_W'(pln_prod >> (F + 4));
      if (cmd.vsq)     sq_ff   <= SQW'(s_sq >> F);
      if (cmd.ent_latch) begin
         ent_mean_ff <= (mode_ff != MODE_VARIANCE) ? OUT_W'(TOTAL_W'(0) - ent_q) : '0;
      end
      if (cmd.res_load) begin
         rsp_ent_ff  <= ent_mean_ff;
         rsp_var_ff  <= (mode_ff != MODE_ENTROPY) ? var_q : '0;
         rsp_last_ff <= last_c;
      end
      if (reset) begin
         mode_ff      <= MODE_BOTH;
         gcount_ff    <= GCOUNT_W'(2);
         icount_ff    <= CNT_W'(1);
         pcount_ff    <= CNT_W'(1);
         ent_tot_ff   <= '0;
         var_tot_ff   <= '0;
         s_ff         <= '0;
         ss_ff        <= '0;
         geno_ff      <= '0;
         ind_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_MODE:        mode_ff   <= csr_wdata[MODE_W-1:0];
               REG_GENOTYPES:   gcount_ff <= csr_wdata[GCOUNT_W-1:0];
               REG_INDIVIDUALS: icount_ff <= csr_wdata;
               REG_POSITIONS:   pcount_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.acc) begin
            if (mode_ff != MODE_VARIANCE && p_ff != '0) ent_tot_ff <= ent_tot_ff + term_ff;
            if (mode_ff != MODE_ENTROPY) begin
               s_ff  <= s_ff + SW'((PW+KW)'(p_ff) * (PW+KW)'(geno_ff));
               ss_ff <= ss_ff + SSW'((PW+2*KW)'(p_ff) * (PW+2*KW)'(kk));
            end
            geno_ff <= status.geno_end ? '0 : geno_ff + 1'b1;
         end
         if (cmd.vacc) begin
            if (mode_ff != MODE_ENTROPY) var_tot_ff <= var_tot_ff + TOTAL_W'(v_ind);
            s_ff   <= '0;
            ss_ff  <= '0;
            ind_ff <= status.ind_end ? '0 : ind_ff + 1'b1;
         end
         if (cmd.res_load) begin
            pos_ff       <= last_c ? '0 : pos_ff + 1'b1;
            ent_tot_ff   <= '0;
            var_tot_ff   <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entropy_mean  = $signed(rsp_ent_ff);
   assign rsp_variance_mean = rsp_var_ff;
   assign rsp_last_position = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(geno_ff) < 32'(MAX_GENOTYPES))
      else $error("genotype counter out of range");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> y_ff[30] || p_ff == '0)
      else $error("log mantissa not normalized");
   assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> ent_tot_ff == '0 && var_tot_ff == '0)
      else $error("totals not cleared after result");
endmodule

// ===== hw/rtl/mean_entropy_variance_accumulator_core.sv =====
// ---------------------------------------------------------------------------
// Mean entropy / variance accumulator core
// Accumulates p*ln(p) and genotype index variance per position and emits means.
// ---------------------------------------------------------------------------
// Sequence: each input transaction takes one load, 24 log squaring steps in
// the 31x31 multiplier, two multiply steps and an accumulate. A transaction
// that closes an individual adds a square and a variance accumulate, and one
// that closes a position adds two 48-step divisions by the individual count
// and waits for a free result register. A new transaction waits for the last.
// Reset (synchronous, active high) restores the register defaults and clears
// all totals and counters; the block is ready the cycle after reset is released.
// ---------------------------------------------------------------------------
module mean_entropy_variance_accumulator_core import meva_pkg::*; #(
   parameter int MAX_GENOTYPES  = 16,
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PROB_FRAC_BITS:0] req_prob,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_entropy_mean,
   output logic [OUT_W-1:0]        rsp_variance_mean,
   output logic                    rsp_last_position,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);
   cmd_type            cmd;
   status_type         status;
   logic               div_busy;
   logic [TOTAL_W-1:0] div_dividend, div_quotient;
   logic [CNT_W-1:0]   div_divisor;

   // Configuration writes must only be issued while the core is idle; the core
   // does not enforce this, and the register port always accepts a transaction.
   assign csr_ready = 1'b1;

   meva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   meva_dp #(
      .MAX_GENOTYPES  (MAX_GENOTYPES),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_prob          (req_prob),
      .cmd               (cmd),
      .status            (status),
      .div_busy          (div_busy),
      .div_dividend      (div_dividend),
      .div_divisor       (div_divisor),
      .div_quotient      (div_quotient),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_entropy_mean  (rsp_entropy_mean),
      .rsp_variance_mean (rsp_variance_mean),
      .rsp_last_position (rsp_last_position)
   );

   // One divider serves both means: entropy first, then variance.
   meva_div #(
      .DW (TOTAL_W),
      .VW (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // A transaction is processed alone: the core stays busy after accepting one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && div_busy))
      else $error("ready while dividing");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.res_load))
      else $error("result raised without load");
endmodule
